// ----- rtl/sha1md_pkg.sv -----
`default_nettype none

package sha1md_pkg;

   // one queued command, already stripped of items that do nothing
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } cmd_type;

   // write side of the command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_push_type;

   // head of the command queue as seen by the engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned ROUNDS       = 80;

   localparam logic [2:0] LAST_WORD   = 3'(DIGEST_WORDS - 1);
   localparam logic [6:0] LAST_ROUND  = 7'(ROUNDS - 1);

   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam logic [5:0]  LAST_POS   = 6'd63;

   localparam logic [31:0] K_ROUND_0  = 32'h5a827999;
   localparam logic [31:0] K_ROUND_1  = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND_2  = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND_3  = 32'hca62c1d6;

   localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   // round constant by quarter
   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = K_ROUND_0;
      end else if (rnd < 7'd40) begin
         k = K_ROUND_1;
      end else if (rnd < 7'd60) begin
         k = K_ROUND_2;
      end else begin
         k = K_ROUND_3;
      end
      return k;
   endfunction

   // boolean round function by quarter
   function automatic logic [31:0] round_f(input logic [6:0]  rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sha1md_queue.sv -----
`default_nettype none

module sha1md_queue #(
   parameter int DEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  sha1md_pkg::q_push_type push,
   output logic                  full,
   output sha1md_pkg::q_head_type head,
   input  wire                   pop
);
   import sha1md_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && (count_ff != '0);

   // show-ahead head of the queue
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sha1md_front.sv -----
`default_nettype none

module sha1md_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [7:0]            req_data_byte,
   input  wire                   req_byte_present,
   input  wire                   req_end_of_message,
   output sha1md_pkg::q_push_type push,
   input  wire                   q_full
);
   import sha1md_pkg::*;

   logic    hold_valid_ff;
   cmd_type hold_cmd_ff;
   logic    req_accept;
   logic    useful;
   logic    can_load;

   // items with neither a byte nor an end mark are dropped here
   assign useful     = req_byte_present || req_end_of_message;
   assign can_load   = !hold_valid_ff || !q_full;
   assign req_stall  = !can_load;
   assign req_accept = req_valid && !req_stall;

   assign push.valid = hold_valid_ff;
   assign push.cmd   = hold_cmd_ff;

   // input holding stage in front of the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (can_load) begin
         hold_valid_ff <= req_accept && useful;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && can_load) begin
         hold_cmd_ff.data_byte      <= req_data_byte;
         hold_cmd_ff.byte_present   <= req_byte_present;
         hold_cmd_ff.end_of_message <= req_end_of_message;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sha1md_engine.sv -----
`default_nettype none

module sha1md_engine (
   input  wire                    clock,
   input  wire                    reset,
   input  sha1md_pkg::q_head_type  head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [31:0]            rsp_digest_word,
   output logic [2:0]             rsp_word_number,
   output logic                   rsp_final_word
);
   import sha1md_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // where to go once a compression is folded in
   typedef enum logic [1:0] {
      RET_IDLE,
      RET_PAD,
      RET_LEN,
      RET_EMIT
   } ret_type;

   state_type          state_ff;
   ret_type            ret_ff;
   logic [3:0][7:0]    buf_ff   [BLOCK_WORDS];
   logic [31:0]        chain_ff [DIGEST_WORDS];
   logic [31:0]        a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0]        len_ff;
   logic [6:0]         round_ff;
   logic [2:0]         word_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_digest_word_ff;
   logic [2:0]         rsp_word_number_ff;
   logic               rsp_final_word_ff;

   logic [5:0]         pos;
   logic [3:0]         widx;
   logic [1:0]         lane;
   logic [31:0]        sched_in;
   logic [31:0]        t_in;
   logic               rsp_free;

   assign pos  = len_ff[8:3];
   assign widx = pos[5:2];
   assign lane = 2'd3 - pos[1:0];

   assign pop      = (state_ff == ST_IDLE) && head.valid;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // message schedule: next word from the sliding 16-word window
   always_comb begin
      sched_in = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
      sched_in = {sched_in[30:0], sched_in[31]};
   end

   // one compression round
   assign t_in = {a_ff[26:0], a_ff[31:27]} + round_f(round_ff, b_ff, c_ff, d_ff)
                 + e_ff + round_k(round_ff) + buf_ff[0];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_digest_word_ff;
   assign rsp_word_number = rsp_word_number_ff;
   assign rsp_final_word  = rsp_final_word_ff;

   // sequencer, block buffer, hash state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= RET_IDLE;
         len_ff       <= '0;
         round_ff     <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         // result register drains while the sequencer is not emitting
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (head.valid) begin
                  if (head.cmd.byte_present) begin
                     buf_ff[widx][lane] <= head.cmd.data_byte;
                     len_ff             <= len_ff + 64'd8;
                     if (pos == LAST_POS) begin
                        a_ff     <= chain_ff[0];
                        b_ff     <= chain_ff[1];
                        c_ff     <= chain_ff[2];
                        d_ff     <= chain_ff[3];
                        e_ff     <= chain_ff[4];
                        round_ff <= '0;
                        ret_ff   <= head.cmd.end_of_message ? RET_PAD : RET_IDLE;
                        state_ff <= ST_ROUND;
                     end else if (head.cmd.end_of_message) begin
                        state_ff <= ST_PAD;
                     end
                  end else if (head.cmd.end_of_message) begin
                     state_ff <= ST_PAD;
                  end
               end
            end

            // end marker byte; spill to an extra block when no room for length
            ST_PAD: begin
               buf_ff[widx][lane] <= PAD_BYTE;
               if (pos[5:3] == 3'b111) begin
                  a_ff     <= chain_ff[0];
                  b_ff     <= chain_ff[1];
                  c_ff     <= chain_ff[2];
                  d_ff     <= chain_ff[3];
                  e_ff     <= chain_ff[4];
                  round_ff <= '0;
                  ret_ff   <= RET_LEN;
                  state_ff <= ST_ROUND;
               end else begin
                  state_ff <= ST_LEN;
               end
            end

            // bit length into the last two words, then the final block
            ST_LEN: begin
               buf_ff[14] <= len_ff[63:32];
               buf_ff[15] <= len_ff[31:0];
               a_ff       <= chain_ff[0];
               b_ff       <= chain_ff[1];
               c_ff       <= chain_ff[2];
               d_ff       <= chain_ff[3];
               e_ff       <= chain_ff[4];
               round_ff   <= '0;
               ret_ff     <= RET_EMIT;
               state_ff   <= ST_ROUND;
            end

            ST_ROUND: begin
               e_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= {b_ff[1:0], b_ff[31:2]};
               b_ff <= a_ff;
               a_ff <= t_in;
               for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                  buf_ff[i] <= buf_ff[i + 1];
               end
               buf_ff[BLOCK_WORDS - 1] <= sched_in;
               round_ff <= round_ff + 7'd1;
               if (round_ff == LAST_ROUND) begin
                  state_ff <= ST_FINISH;
               end
            end

            // fold the working variables into the chain and clear the block
            ST_FINISH: begin
               chain_ff[0] <= chain_ff[0] + a_ff;
               chain_ff[1] <= chain_ff[1] + b_ff;
               chain_ff[2] <= chain_ff[2] + c_ff;
               chain_ff[3] <= chain_ff[3] + d_ff;
               chain_ff[4] <= chain_ff[4] + e_ff;
               for (int i = 0; i < BLOCK_WORDS; i++) begin
                  buf_ff[i] <= '0;
               end
               round_ff <= '0;
               word_ff  <= '0;
               unique case (ret_ff)
                  RET_IDLE: state_ff <= ST_IDLE;
                  RET_PAD:  state_ff <= ST_PAD;
                  RET_LEN:  state_ff <= ST_LEN;
                  RET_EMIT: state_ff <= ST_EMIT;
                  default:  state_ff <= ST_IDLE;
               endcase
            end

            // one digest beat per free slot in the result register
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_digest_word_ff <= chain_ff[word_ff];
                  rsp_word_number_ff <= word_ff;
                  rsp_final_word_ff  <= (word_ff == LAST_WORD);
                  if (word_ff == LAST_WORD) begin
                     for (int i = 0; i < DIGEST_WORDS; i++) begin
                        chain_ff[i] <= INIT_HASH[i];
                     end
                     len_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     word_ff <= word_ff + 3'd1;
                  end
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sha1_message_digest_top.sv -----
`default_nettype none

// SHA-1 digest of a byte stream.
// Request channel: one beat per item, req_data_byte counted when
// req_byte_present is high; req_end_of_message closes the message (with or
// without a byte) and starts padding, the length block and the digest.
// Beats with neither flag are dropped at the input stage.
// Response channel: five beats per message, word 0 (most significant) first,
// rsp_final_word high on word 4.
// Input beats pass a holding stage and a short command queue, so the request
// side keeps flowing while the engine compresses, up to QUEUE_DEPTH + 1 beats.
// The engine takes one byte per cycle while idle; the 64th byte of a block
// starts the compression round loop and a fold into the chain, during which
// no bytes are taken and further beats wait in the queue.
// End of message: the pad byte is written, then the length is loaded and the
// length block compressed (after an extra block when the length does not fit),
// then five result beats, one per cycle while rsp_stall stays low.
// Reset (synchronous, active high) loads the initial hash, clears the block
// and empties the queue. A stall on rsp_stall holds the current result beat;
// the engine waits for the result register and back-pressure then reaches
// req_stall once the queue fills.
module sha1_message_digest_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_byte_present,
   input  wire         req_end_of_message,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_final_word
);
   import sha1md_pkg::*;

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   // input stage: accept and classify beats
   sha1md_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .push               (q_push),
      .q_full             (q_full)
   );

   // command queue between front and engine
   sha1md_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .head  (q_head),
      .pop   (q_pop)
   );

   // packing, padding, compression and digest output
   sha1md_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_number (rsp_word_number),
      .rsp_final_word  (rsp_final_word)
   );

endmodule

`default_nettype wire
